@@ src/sqlkt_pkg.sv @@
// Package for the SQL keyword tokenizer: character codes, keyword table,
// and small character helpers. No dependencies.
package sqlkt_pkg;

  localparam int unsigned MaxTokenLenDef = 255;
  localparam int unsigned NumKw          = 6;

  localparam logic [2:0] KwNone   = 3'd6;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] CaseDiff = 8'h20;

  localparam logic signed [7:0] DepthMax = 8'sd127;
  localparam logic signed [7:0] DepthMin = -8'sd128;

  // keyword lengths, indexed by keyword number
  localparam logic [2:0] KW_LEN [NumKw] = '{3'd6, 3'd4, 3'd5, 3'd2, 3'd2, 3'd3};

  // keyword text, [keyword][position]; unused positions are zero
  localparam logic [7:0] KW_TEXT [NumKw][6] = '{
    '{8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54},  // SELECT
    '{8'h46, 8'h52, 8'h4F, 8'h4D, 8'h00, 8'h00},  // FROM
    '{8'h47, 8'h52, 8'h4F, 8'h55, 8'h50, 8'h00},  // GROUP
    '{8'h42, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00},  // BY
    '{8'h41, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},  // AS
    '{8'h53, 8'h55, 8'h4D, 8'h00, 8'h00, 8'h00}   // SUM
  };

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= ChLowA && c <= ChLowZ) begin
      return c - CaseDiff;
    end
    return c;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == ChSpace) || (c == ChSemi) || (c == ChComma) || (c == ChNul) ||
           (c == ChLParen) || (c == ChRParen);
  endfunction

endpackage

@@ src/sql_keyword_tokenizer.sv @@
// Top level of the SQL keyword tokenizer: byte register, token/depth update,
// result register. Depends on sqlkt_pkg.
//
// Channel  | Direction | Handshake                | Payload
// in       | input     | in_valid_i / in_stall_o  | in_byte_i
// out      | output    | out_valid_o / out_stall_i| out_char_o, token_end_o, keyword_hit_o,
//          |           |                          | keyword_index_o, token_length_o,
//          |           |                          | nest_depth_o
//
// One byte per cycle unless the output stalls; byte register, then result register.
// The rate is set by the depth/length/candidate update loop.
// Reset clears depth to 0, the token length to 0 and all keyword candidates to set.
// A stalled output holds the result register; the byte register then holds too,
// and the input stalls only while both are full.
module sql_keyword_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = sqlkt_pkg::MaxTokenLenDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic              token_end_o,
  output logic              keyword_hit_o,
  output logic [2:0]        keyword_index_o,
  output logic [7:0]        token_length_o,
  output logic signed [7:0] nest_depth_o
);
  import sqlkt_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN + 1);

  logic               byte_valid_q;
  logic [7:0]         byte_q;
  logic               advance;
  logic               load;
  logic               work;

  logic signed [7:0]  depth_q, depth_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [NumKw-1:0]   cand_q, cand_d;

  logic               ends;
  logic [7:0]         up;
  logic [2:0]         pos;
  logic [NumKw-1:0]   keep;
  logic [2:0]         kw_idx;
  logic [LenW-1:0]    len_inc;
  logic [16:0]        len_ext;
  logic [7:0]         len_clamp;

  logic               res_valid_d;
  logic [7:0]         char_d;
  logic               end_d;
  logic [2:0]         idx_d;

  logic               out_valid_q;
  logic [7:0]         out_char_q;
  logic               token_end_q;
  logic               keyword_hit_q;
  logic [2:0]         keyword_index_q;
  logic [7:0]         token_length_q;
  logic signed [7:0]  nest_depth_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = !byte_valid_q || advance;
  assign in_stall_o = !load;
  assign work       = byte_valid_q && advance;

  always_comb begin
    depth_d = depth_q;
    if (byte_q == ChLParen && depth_q < DepthMax) begin
      depth_d = depth_q + 8'sd1;
    end else if (byte_q == ChRParen && depth_q > DepthMin) begin
      depth_d = depth_q - 8'sd1;
    end
    ends = is_delim(byte_q) && (depth_d == 8'sd0 || (byte_q == ChLParen && depth_d == 8'sd1));
    up   = upcase(byte_q);
    pos  = (len_q < LenW'(6)) ? len_q[2:0] : 3'd0;
    for (int k = 0; k < NumKw; k++) begin
      keep[k] = (len_q < LenW'(KW_LEN[k])) && (KW_TEXT[k][pos] == up);
    end
    kw_idx = KwNone;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (cand_q[k] && len_q == LenW'(KW_LEN[k])) begin
        kw_idx = 3'(k);
      end
    end
    len_inc = (len_q < LenW'(MAX_TOKEN_LEN)) ? len_q + LenW'(1) : len_q;

    if (ends) begin
      len_d       = '0;
      cand_d      = '1;
      res_valid_d = (len_q != '0);
      char_d      = ChNul;
      end_d       = 1'b1;
      idx_d       = kw_idx;
      len_ext     = 17'(len_q);
    end else begin
      len_d       = len_inc;
      cand_d      = cand_q & keep;
      res_valid_d = 1'b1;
      char_d      = up;
      end_d       = 1'b0;
      idx_d       = KwNone;
      len_ext     = 17'(len_inc);
    end
    len_clamp = (len_ext > 17'd255) ? 8'hFF : len_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      depth_q      <= '0;
      len_q        <= '0;
      cand_q       <= '1;
    end else begin
      if (load) begin
        byte_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q  <= work && res_valid_d;
      end
      if (work) begin
        depth_q <= depth_d;
        len_q   <= len_d;
        cand_q  <= cand_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
    if (work) begin
      out_char_q      <= char_d;
      token_end_q     <= end_d;
      keyword_hit_q   <= end_d && (kw_idx != KwNone);
      keyword_index_q <= idx_d;
      token_length_q  <= len_clamp;
      nest_depth_q    <= depth_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign token_end_o     = token_end_q;
  assign keyword_hit_o   = keyword_hit_q;
  assign keyword_index_o = keyword_index_q;
  assign token_length_o  = token_length_q;
  assign nest_depth_o    = nest_depth_q;

endmodule

@@ src/sqlkt_checker.sv @@
// Port-level checks for the SQL keyword tokenizer result channel, bound to the
// top level. Depends on sqlkt_pkg.
module sqlkt_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_char_i,
  input logic       token_end_i,
  input logic       keyword_hit_i,
  input logic [2:0] keyword_index_i,
  input logic [7:0] token_length_i
);
  import sqlkt_pkg::*;

  a_end_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_end_i |-> out_char_i == ChNul)
    else $error("token end transfer carries a nonzero character");

  a_char_no_kw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !token_end_i |-> !keyword_hit_i && keyword_index_i == KwNone)
    else $error("character transfer flags a keyword");

  a_kw_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_end_i |-> keyword_hit_i == (keyword_index_i != KwNone))
    else $error("keyword flag disagrees with keyword index");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> token_length_i != 8'd0)
    else $error("transfer with zero token length");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_char_i) &&
                                   $stable(token_length_i))
    else $error("stalled result changed");

endmodule

bind sql_keyword_tokenizer sqlkt_props u_sqlkt_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_char_i      (out_char_o),
  .token_end_i     (token_end_o),
  .keyword_hit_i   (keyword_hit_o),
  .keyword_index_i (keyword_index_o),
  .token_length_i  (token_length_o)
);
